@@ rtl/core/scq_pkg.sv @@
`timescale 1ns / 1ps
package scq_pkg;

  // one queued key event
  typedef struct packed {
    logic [7:0] ascii;
    logic [7:0] code;
  } kbd_entry_t;

  // operation broadcast to every cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_SHIFT  = 2'd1,
    CELL_ROT    = 2'd2,
    CELL_APPEND = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    kbd_entry_t din;
  } cell_ctrl_t;

  // item kinds
  localparam logic [1:0] KIND_PUSH    = 2'd0;
  localparam logic [1:0] KIND_CONSUME = 2'd1;
  localparam logic [1:0] KIND_POP     = 2'd2;

  // set 1 break flag
  localparam logic [7:0] BREAK_MASK = 8'h80;

  function automatic logic is_make(input kbd_entry_t e);
    return (e.code & BREAK_MASK) == 8'h00;
  endfunction

endpackage

@@ rtl/core/scq_intf.sv @@
`timescale 1ns / 1ps
// key event channel
interface scq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] key_ascii;
  logic [7:0] key_scancode;

  modport source (output valid, kind, key_ascii, key_scancode, input ready);
  modport sink   (input valid, kind, key_ascii, key_scancode, output ready);
endinterface

// status channel, one beat per event
interface scq_out_if #(parameter int CNT_W = 5);
  logic             valid;
  logic             ready;
  logic             irq_raise;
  logic             latch_valid;
  logic [7:0]       latch_ascii;
  logic [7:0]       latch_scancode;
  logic             make_pending;
  logic [7:0]       peek_ascii;
  logic [7:0]       peek_scancode;
  logic             popped_valid;
  logic [7:0]       popped_ascii;
  logic [7:0]       popped_scancode;
  logic             push_dropped;
  logic [CNT_W-1:0] queued_count;

  modport source (output valid, irq_raise, latch_valid, latch_ascii, latch_scancode,
                  make_pending, peek_ascii, peek_scancode, popped_valid, popped_ascii,
                  popped_scancode, push_dropped, queued_count, input ready);
  modport sink   (input valid, irq_raise, latch_valid, latch_ascii, latch_scancode,
                  make_pending, peek_ascii, peek_scancode, popped_valid, popped_ascii,
                  popped_scancode, push_dropped, queued_count, output ready);
endinterface

@@ rtl/core/scancode_queue_break_preserving.sv @@
`timescale 1ns / 1ps
// Sequence: an accepted event goes from ST_IDLE to ST_SCAN, which rotates every queued entry
// past the head and restores order, then to ST_DONE, which loads the result register; a break
// pushed into a full queue walks the whole row in ST_EVICT instead of ST_SCAN; a pop first
// takes latch entries in ST_POP until a make leaves the latch. Throughput: one event at a time,
// set by the walk that rotates every queued entry past the head to find the first make code.
// Reset: synchronous active low; empties latch and queue, no clearing pass needed.
module scancode_queue_break_preserving
  import scq_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  scq_in_if.sink       in_ch,
  scq_out_if.source    out_ch
);

  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(RING_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_POP   = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_EVICT = 5'b01000,
    ST_DONE  = 5'b10000
  } scq_state_t;

  scq_state_t      state_r, state_nxt;
  logic            latch_full_r, latch_full_nxt;
  kbd_entry_t      latch_r, latch_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] steps_r, steps_nxt;
  kbd_entry_t      push_r, push_nxt;
  logic            irq_r, irq_nxt;
  logic            drop_r, drop_nxt;
  logic            pop_valid_r, pop_valid_nxt;
  kbd_entry_t      pop_entry_r, pop_entry_nxt;
  logic            peek_found_r, peek_found_nxt;
  kbd_entry_t      peek_entry_r, peek_entry_nxt;
  logic            evicted_r, evicted_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_irq_r, out_lv_r, out_pend_r, out_popv_r, out_drop_r;
  kbd_entry_t      out_latch_r, out_peek_r, out_pop_r;
  logic [CntW-1:0] out_cnt_r;

  cell_ctrl_t      ctrl;
  logic            head_valid;
  kbd_entry_t      head_entry;
  kbd_entry_t      in_entry;
  logic            in_beat;
  logic            consume_req;
  logic            load_steps;
  logic            out_load;
  logic            latch_make;

  assign in_entry = '{ascii: in_ch.key_ascii, code: in_ch.key_scancode};
  assign in_beat  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign latch_make = latch_full_r && is_make(latch_r);

  scq_cell_row #(.DEPTH(RING_DEPTH)) u_row (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    latch_full_nxt = latch_full_r;
    latch_nxt      = latch_r;
    count_nxt      = count_r;
    steps_nxt      = steps_r;
    push_nxt       = push_r;
    irq_nxt        = irq_r;
    drop_nxt       = drop_r;
    pop_valid_nxt  = pop_valid_r;
    pop_entry_nxt  = pop_entry_r;
    peek_found_nxt = peek_found_r;
    peek_entry_nxt = peek_entry_r;
    evicted_nxt    = evicted_r;
    ctrl.op        = CELL_HOLD;
    ctrl.din       = push_r;
    consume_req    = 1'b0;
    load_steps     = 1'b0;
    out_load       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          irq_nxt        = 1'b0;
          drop_nxt       = 1'b0;
          pop_valid_nxt  = 1'b0;
          pop_entry_nxt  = '0;
          peek_found_nxt = 1'b0;
          peek_entry_nxt = '0;
          evicted_nxt    = 1'b0;
          push_nxt       = in_entry;
          state_nxt      = ST_SCAN;
          load_steps     = 1'b1;
          priority if (in_ch.kind == KIND_PUSH) begin
            if (!latch_full_r) begin
              latch_nxt      = in_entry;
              latch_full_nxt = 1'b1;
              irq_nxt        = 1'b1;
            end else if (count_r != DepthCnt) begin
              ctrl.op   = CELL_APPEND;
              ctrl.din  = in_entry;
              count_nxt = count_r + 1'b1;
              irq_nxt   = 1'b1;
            end else if (!is_make(in_entry)) begin
              // full queue, break code: make room by dropping the oldest make
              state_nxt  = ST_EVICT;
              load_steps = 1'b0;
              steps_nxt  = DepthCnt;
            end else begin
              drop_nxt = 1'b1;
            end
          end else if (in_ch.kind == KIND_CONSUME) begin
            consume_req = 1'b1;
          end else if (in_ch.kind == KIND_POP) begin
            state_nxt  = ST_POP;
            load_steps = 1'b0;
          end else begin
            // unknown kind: status only
          end
        end
      end

      ST_POP: begin
        // one consume per cycle until a make code leaves the latch or the latch is empty
        if (!latch_full_r) begin
          state_nxt  = ST_SCAN;
          load_steps = 1'b1;
        end else begin
          consume_req = 1'b1;
          if (is_make(latch_r)) begin
            pop_valid_nxt = 1'b1;
            pop_entry_nxt = latch_r;
            state_nxt     = ST_SCAN;
            load_steps    = 1'b1;
          end
        end
      end

      ST_SCAN: begin
        // full rotation restores order; note the first make passing the head
        if (steps_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          ctrl.op   = CELL_ROT;
          steps_nxt = steps_r - 1'b1;
          if (!peek_found_r && head_valid && is_make(head_entry)) begin
            peek_found_nxt = 1'b1;
            peek_entry_nxt = head_entry;
          end
        end
      end

      ST_EVICT: begin
        if (steps_r == '0) begin
          if (evicted_r) begin
            ctrl.op   = CELL_APPEND;
            count_nxt = count_r + 1'b1;
            irq_nxt   = 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          state_nxt = ST_DONE;
        end else begin
          steps_nxt = steps_r - 1'b1;
          if (!evicted_r && is_make(head_entry)) begin
            // drop the oldest make, everything behind closes up
            ctrl.op     = CELL_SHIFT;
            evicted_nxt = 1'b1;
            count_nxt   = count_r - 1'b1;
          end else begin
            ctrl.op = CELL_ROT;
            if (evicted_r && !peek_found_r && is_make(head_entry)) begin
              peek_found_nxt = 1'b1;
              peek_entry_nxt = head_entry;
            end
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // latch load from the queue head
    if (consume_req) begin
      if (count_r != '0) begin
        latch_nxt      = head_entry;
        latch_full_nxt = 1'b1;
        ctrl.op        = CELL_SHIFT;
        count_nxt      = count_r - 1'b1;
        irq_nxt        = 1'b1;
      end else begin
        latch_nxt      = '0;
        latch_full_nxt = 1'b0;
      end
    end

    if (load_steps) begin
      steps_nxt = count_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      latch_full_r <= 1'b0;
      latch_r      <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      latch_full_r <= latch_full_nxt;
      latch_r      <= latch_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r      <= steps_nxt;
    push_r       <= push_nxt;
    irq_r        <= irq_nxt;
    drop_r       <= drop_nxt;
    pop_valid_r  <= pop_valid_nxt;
    pop_entry_r  <= pop_entry_nxt;
    peek_found_r <= peek_found_nxt;
    peek_entry_r <= peek_entry_nxt;
    evicted_r    <= evicted_nxt;
    if (out_load) begin
      out_irq_r   <= irq_r;
      out_lv_r    <= latch_full_r;
      out_latch_r <= latch_full_r ? latch_r : '0;
      out_pend_r  <= latch_make || peek_found_r;
      out_peek_r  <= latch_make ? latch_r : (peek_found_r ? peek_entry_r : '0);
      out_popv_r  <= pop_valid_r;
      out_pop_r   <= pop_valid_r ? pop_entry_r : '0;
      out_drop_r  <= drop_r;
      out_cnt_r   <= count_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.irq_raise       = out_irq_r;
  assign out_ch.latch_valid     = out_lv_r;
  assign out_ch.latch_ascii     = out_latch_r.ascii;
  assign out_ch.latch_scancode  = out_latch_r.code;
  assign out_ch.make_pending    = out_pend_r;
  assign out_ch.peek_ascii      = out_peek_r.ascii;
  assign out_ch.peek_scancode   = out_peek_r.code;
  assign out_ch.popped_valid    = out_popv_r;
  assign out_ch.popped_ascii    = out_pop_r.ascii;
  assign out_ch.popped_scancode = out_pop_r.code;
  assign out_ch.push_dropped    = out_drop_r;
  assign out_ch.queued_count    = out_cnt_r;

endmodule

@@ rtl/core/scq_cell.sv @@
`timescale 1ns / 1ps
module scq_cell
  import scq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  kbd_entry_t head_entry,
  input  logic       left_valid,
  input  logic       right_valid,
  input  kbd_entry_t right_entry,
  output logic       valid_o,
  output kbd_entry_t entry_o
);

  logic       valid_r, valid_nxt;
  kbd_entry_t entry_r, entry_nxt;

  // shift toward the head, rotate the head to the tail, or take an append
  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    unique case (ctrl.op)
      CELL_HOLD: ;
      CELL_SHIFT: begin
        valid_nxt = right_valid;
        entry_nxt = right_entry;
      end
      CELL_ROT: begin
        if (right_valid) begin
          entry_nxt = right_entry;
        end else if (valid_r) begin
          entry_nxt = head_entry; // tail cell takes the old head
        end
      end
      CELL_APPEND: begin
        if (!valid_r && left_valid) begin
          valid_nxt = 1'b1;
          entry_nxt = ctrl.din;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign valid_o = valid_r;
  assign entry_o = entry_r;

endmodule

@@ rtl/core/scq_cell_row.sv @@
`timescale 1ns / 1ps
module scq_cell_row
  import scq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  output logic       head_valid,
  output kbd_entry_t head_entry
);

  logic [DEPTH-1:0] cell_valid;
  kbd_entry_t       cell_entry [DEPTH];

  // cell 0 is the oldest entry; occupied cells stay packed toward it
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       lv;
    logic       rv;
    kbd_entry_t re;

    if (i == 0) begin : g_first
      assign lv = 1'b1;
    end else begin : g_mid_l
      assign lv = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign re = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[i+1];
      assign re = cell_entry[i+1];
    end

    scq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .head_entry  (head_entry),
      .left_valid  (lv),
      .right_valid (rv),
      .right_entry (re),
      .valid_o     (cell_valid[i]),
      .entry_o     (cell_entry[i])
    );
  end

  assign head_valid = cell_valid[0];
  assign head_entry = cell_entry[0];

endmodule

@@ rtl/core/scq_checker.sv @@
`timescale 1ns / 1ps
module scq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       irq_raise,
  input logic       latch_valid,
  input logic [7:0] latch_ascii,
  input logic [7:0] latch_scancode,
  input logic       popped_valid,
  input logic [7:0] popped_scancode,
  input logic       push_dropped
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a pop only ever returns a make code
  a_pop_make: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && popped_valid |-> !popped_scancode[7])
    else $error("popped a break code");

  // an empty latch reads as zero
  a_latch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !latch_valid |-> (latch_ascii == 8'h00) && (latch_scancode == 8'h00))
    else $error("empty latch shows data");

  // a dropped push raises no interrupt and pops nothing, and leaves the latch full
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && push_dropped |-> !irq_raise && !popped_valid && latch_valid)
    else $error("dropped push with side effects");

endmodule

bind scancode_queue_break_preserving scq_checker u_scq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .irq_raise       (out_ch.irq_raise),
  .latch_valid     (out_ch.latch_valid),
  .latch_ascii     (out_ch.latch_ascii),
  .latch_scancode  (out_ch.latch_scancode),
  .popped_valid    (out_ch.popped_valid),
  .popped_scancode (out_ch.popped_scancode),
  .push_dropped    (out_ch.push_dropped)
);

@@ bench/tb_scancode_queue_break_preserving.sv @@
`timescale 1ns / 1ps
module tb_scancode_queue_break_preserving
  import scq_pkg::*;
();

  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned TARGET_EVENTS = 1000;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // status reported for one event
  typedef struct packed {
    logic       irq_raise;
    logic       latch_valid;
    logic [7:0] latch_ascii;
    logic [7:0] latch_scancode;
    logic       make_pending;
    logic [7:0] peek_ascii;
    logic [7:0] peek_scancode;
    logic       popped_valid;
    logic [7:0] popped_ascii;
    logic [7:0] popped_scancode;
    logic       push_dropped;
    logic [4:0] queued_count;
  } kbd_status_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_t;

  // Tracks latch and ring contents and the status beats they imply
  class key_status_board;
    kbd_entry_t  latch;
    bit          latch_full;
    kbd_entry_t  ring [RING_DEPTH];
    int unsigned head, tail, fill;
    kbd_status_t expected_status [$];
    int          mismatches;

    function new();
      latch = '0;
      latch_full = 0;
      foreach (ring[i]) ring[i] = '0;
      head = 0;
      tail = 0;
      fill = 0;
      mismatches = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] %s", $realtime, msg);
    endfunction

    // data port read: refill latch from ring head, or empty it
    function bit load_latch();
      if (fill > 0) begin
        latch = ring[head];
        head = (head + 1) % RING_DEPTH;
        fill--;
        latch_full = 1;
        return 1;
      end
      latch = '0;
      latch_full = 0;
      return 0;
    endfunction

    // returns 1 when the event was kept
    function bit take_push(kbd_entry_t ev);
      int unsigned pos, prv;
      bit found;
      found = 0;
      pos = 0;
      if (!latch_full) begin
        latch = ev;
        latch_full = 1;
        return 1;
      end
      if (fill >= RING_DEPTH) begin
        if ((ev.code & BREAK_MASK) == 8'h00) return 0;
        // oldest queued make gets evicted to make room for the break
        for (int unsigned i = 0; i < fill; i++) begin
          if (!found && (ring[(head + i) % RING_DEPTH].code & BREAK_MASK) == 8'h00) begin
            pos = (head + i) % RING_DEPTH;
            found = 1;
          end
        end
        if (!found) return 0;
        while (pos != head) begin
          prv = (pos + RING_DEPTH - 1) % RING_DEPTH;
          ring[pos] = ring[prv];
          pos = prv;
        end
        head = (head + 1) % RING_DEPTH;
        fill--;
      end
      ring[tail] = ev;
      tail = (tail + 1) % RING_DEPTH;
      fill++;
      return 1;
    endfunction

    function void note_event(logic [1:0] kind, kbd_entry_t ev);
      kbd_status_t st;
      kbd_entry_t  taken;
      bit          found;
      st = '0;
      found = 0;
      case (kind)
        KIND_PUSH: begin
          if (take_push(ev)) st.irq_raise = 1;
          else st.push_dropped = 1;
        end
        KIND_CONSUME: begin
          if (load_latch()) st.irq_raise = 1;
        end
        KIND_POP: begin
          // discard breaks until a make leaves the latch
          while (latch_full) begin
            taken = latch;
            if (load_latch()) st.irq_raise = 1;
            if ((taken.code & BREAK_MASK) == 8'h00) begin
              st.popped_valid = 1;
              st.popped_ascii = taken.ascii;
              st.popped_scancode = taken.code;
              break;
            end
          end
        end
        default: ;
      endcase

      // first pending make: latch first, then ring from head
      if (latch_full && (latch.code & BREAK_MASK) == 8'h00) begin
        st.make_pending = 1;
        st.peek_ascii = latch.ascii;
        st.peek_scancode = latch.code;
      end else begin
        for (int unsigned i = 0; i < fill; i++) begin
          if (!found && (ring[(head + i) % RING_DEPTH].code & BREAK_MASK) == 8'h00) begin
            found = 1;
            st.make_pending = 1;
            st.peek_ascii = ring[(head + i) % RING_DEPTH].ascii;
            st.peek_scancode = ring[(head + i) % RING_DEPTH].code;
          end
        end
      end

      st.latch_valid = latch_full;
      st.latch_ascii = latch_full ? latch.ascii : 8'h00;
      st.latch_scancode = latch_full ? latch.code : 8'h00;
      st.queued_count = 5'(fill);
      expected_status.push_back(st);
    endfunction

    function void cmp(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) report($sformatf("%s expected %0h got %0h", name, want, got));
    endfunction

    function void check_status(kbd_status_t got);
      kbd_status_t want;
      if (expected_status.size() == 0) begin
        report("status beat with no event outstanding");
        return;
      end
      want = expected_status.pop_front();
      cmp("irq_raise", 8'(want.irq_raise), 8'(got.irq_raise));
      cmp("latch_valid", 8'(want.latch_valid), 8'(got.latch_valid));
      cmp("latch_ascii", want.latch_ascii, got.latch_ascii);
      cmp("latch_scancode", want.latch_scancode, got.latch_scancode);
      cmp("make_pending", 8'(want.make_pending), 8'(got.make_pending));
      cmp("peek_ascii", want.peek_ascii, got.peek_ascii);
      cmp("peek_scancode", want.peek_scancode, got.peek_scancode);
      cmp("popped_valid", 8'(want.popped_valid), 8'(got.popped_valid));
      cmp("popped_ascii", want.popped_ascii, got.popped_ascii);
      cmp("popped_scancode", want.popped_scancode, got.popped_scancode);
      cmp("push_dropped", 8'(want.push_dropped), 8'(got.push_dropped));
      cmp("queued_count", 8'(want.queued_count), 8'(got.queued_count));
    endfunction

    function int outstanding();
      return expected_status.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   idle_cycles;
  int   stall_left;

  key_status_board board;

  scq_in_if in_ch ();
  scq_out_if #(.CNT_W(5)) out_ch ();

  scancode_queue_break_preserving #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // accepted beats on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        board.note_event(in_ch.kind, '{ascii: in_ch.key_ascii, code: in_ch.key_scancode});
      if (out_ch.valid && out_ch.ready)
        board.check_status('{
          irq_raise:       out_ch.irq_raise,
          latch_valid:     out_ch.latch_valid,
          latch_ascii:     out_ch.latch_ascii,
          latch_scancode:  out_ch.latch_scancode,
          make_pending:    out_ch.make_pending,
          peek_ascii:      out_ch.peek_ascii,
          peek_scancode:   out_ch.peek_scancode,
          popped_valid:    out_ch.popped_valid,
          popped_ascii:    out_ch.popped_ascii,
          popped_scancode: out_ch.popped_scancode,
          push_dropped:    out_ch.push_dropped,
          queued_count:    out_ch.queued_count});
    end
  end

  // watchdog: ends the run when no beat moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // present one event and hold it until accepted
  task automatic send_event(input logic [1:0] kind, input logic [7:0] ascii,
                            input logic [7:0] code);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.key_ascii    <= ascii;
    in_ch.key_scancode <= code;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // sender holds off until every status beat is back
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
  endtask

  initial begin
    int         sent;
    int         brk_pct;
    int         len;
    int         r;
    phase_t     ph;
    logic [1:0] kind;
    logic [7:0] code;

    board = new();
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_PUSH;
    in_ch.key_ascii = 8'h00;
    in_ch.key_scancode = 8'h00;
    no_idle = 0;
    sent = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty-state corner cases, then a full ring
    send_event(KIND_NONE, 8'hFF, 8'hFF);
    send_event(KIND_CONSUME, 8'h00, 8'h00);
    send_event(KIND_POP, 8'h00, 8'h00);
    send_event(KIND_PUSH, 8'h00, 8'h00);
    send_event(KIND_PUSH, 8'hFF, 8'hFF);
    send_event(KIND_PUSH, 8'h7F, 8'h7F);
    send_event(KIND_PUSH, 8'h80, 8'h80);
    for (int i = 3; i < RING_DEPTH; i++)
      send_event(KIND_PUSH, 8'(i), (i % 2) ? 8'(8'h80 | i) : 8'(i));
    // full ring: make dropped, break evicts the oldest make
    send_event(KIND_PUSH, 8'h41, 8'h1E);
    send_event(KIND_PUSH, 8'h00, 8'h9E);
    send_event(KIND_POP, 8'h00, 8'h00);
    send_event(KIND_CONSUME, 8'h00, 8'h00);
    send_event(KIND_NONE, 8'h00, 8'h00);
    drain();

    // random phases: fill bursts, drain bursts, mixed traffic and noise
    while (sent < TARGET_EVENTS) begin
      ph = phase_t'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
        0: brk_pct = 0;
        1: brk_pct = 10;
        2: brk_pct = 50;
        3: brk_pct = 90;
        default: brk_pct = 100;
      endcase
      len = $urandom_range(5, 40);
      no_idle = ($urandom_range(0, 4) == 0);
      repeat (len) begin
        r = $urandom_range(0, 99);
        case (ph)
          PH_FILL:  kind = (r < 80) ? KIND_PUSH : (r < 88) ? KIND_CONSUME :
                           (r < 96) ? KIND_POP : KIND_NONE;
          PH_DRAIN: kind = (r < 20) ? KIND_PUSH : (r < 60) ? KIND_CONSUME :
                           (r < 96) ? KIND_POP : KIND_NONE;
          PH_MIXED: kind = (r < 45) ? KIND_PUSH : (r < 70) ? KIND_CONSUME :
                           (r < 95) ? KIND_POP : KIND_NONE;
          default:  kind = 2'($urandom_range(0, 3));
        endcase
        if (ph == PH_NOISE) code = 8'($urandom_range(0, 255));
        else code = {($urandom_range(0, 99) < brk_pct), 7'($urandom_range(0, 127))};
        send_event(kind, 8'($urandom_range(0, 255)), code);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) drain();
    end

    // wind down
    no_idle = 0;
    drain();
    repeat (2 * RING_DEPTH + 8) @(posedge clk);
    if (board.outstanding() != 0)
      board.report($sformatf("%0d status beats never arrived", board.outstanding()));
    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
